// ===== rtl/bdq_pkg.sv =====
// Package for the bounded double-ended queue.
// Holds the command and response payload types, status codes and the
// control and status groups shared by the controller and datapath.
package bdq_pkg;

    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        ACT_PUSH_LEFT  = 2'd0,
        ACT_PUSH_RIGHT = 2'd1,
        ACT_POP_LEFT   = 2'd2,
        ACT_POP_RIGHT  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        action_t                       action;
        logic signed [VALUE_BITS-1:0]  push_value;
    } cmd_item_t;

    typedef struct packed {
        status_t                       status;
        logic                          side;
        logic signed [VALUE_BITS-1:0]  result_value;
    } rsp_item_t;

    typedef struct packed {
        logic exec;
        logic load_direct;
        logic load_read;
    } ctl_t;

    typedef struct packed {
        logic is_push;
        logic refuse;
        logic rsp_busy;
    } sts_t;

endpackage

// ===== rtl/bdq_ctrl.sv =====
// Controller of the bounded double-ended queue.
// Sequences each request and steers the datapath; depends on bdq_pkg.
module bdq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  logic          rsp_ready,
    input  bdq_pkg::sts_t sts,
    output bdq_pkg::ctl_t ctl
);
    import bdq_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign cmd_ready = (state_reg == S_IDLE) && (!sts.rsp_busy || rsp_ready);
    assign accept    = cmd_valid && cmd_ready;

    always_comb
    begin
        ctl.exec        = accept;
        ctl.load_direct = accept && (sts.is_push || sts.refuse);
        ctl.load_read   = (state_reg == S_READ);
        state_next      = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !sts.is_push && !sts.refuse)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/bdq_dp.sv =====
// Datapath of the bounded double-ended queue: ring buffer memory, head
// pointer, entry count, capacity register and response register.
// Depends on bdq_pkg.
module bdq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cap_we,
    input  logic [bdq_pkg::CAP_BITS-1:0]       cap_wdata,
    input  bdq_pkg::cmd_item_t                 cmd,
    input  logic                               rsp_ready,
    output logic                               rsp_valid,
    output bdq_pkg::rsp_item_t                 rsp,
    input  bdq_pkg::ctl_t                      ctl,
    output bdq_pkg::sts_t                      sts
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > CAP_BITS) ? CW : CAP_BITS;

    logic [VALUE_BITS-1:0] mem [DEPTH];

    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CAP_BITS-1:0]   cap_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    rsp_item_t             rsp_reg;
    logic                  pend_side_reg;
    logic [VALUE_BITS-1:0] rd_data_reg;

    logic                  is_push;
    logic                  side;
    logic                  full;
    logic                  empty;
    logic                  refuse;
    logic [KW-1:0]         cap_ext;
    logic [KW-1:0]         eff_cap;
    logic [AW-1:0]         head_inc;
    logic [AW-1:0]         head_dec;
    logic [CW-1:0]         offset;
    logic [AW:0]           right_sum;
    logic [AW-1:0]         right_pos;
    logic [AW-1:0]         addr;

    assign is_push = !cmd.action[1];
    assign side    = cmd.action[0];

    assign cap_ext = KW'(cap_reg);
    assign eff_cap = (cap_ext > KW'(DEPTH)) ? KW'(DEPTH) : cap_ext;
    assign full    = KW'(count_reg) >= eff_cap;
    assign empty   = (count_reg == '0);
    assign refuse  = is_push ? full : empty;

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);

    assign offset    = is_push ? count_reg : count_reg - CW'(1);
    assign right_sum = (AW + 1)'(head_reg) + (AW + 1)'(offset[AW-1:0]);
    assign right_pos = (right_sum >= (AW + 1)'(DEPTH))
                       ? AW'(right_sum - (AW + 1)'(DEPTH)) : right_sum[AW-1:0];

    always_comb
    begin
        if (side)
        begin
            addr = right_pos;
        end
        else
        begin
            addr = is_push ? head_dec : head_reg;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.exec && !refuse)
        begin
            if (is_push)
            begin
                count_next = count_reg + CW'(1);
                if (!side)
                begin
                    head_next = head_dec;
                end
            end
            else
            begin
                count_next = count_reg - CW'(1);
                if (!side)
                begin
                    head_next = head_inc;
                end
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.load_direct || ctl.load_read)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cap_we)
            begin
                cap_reg <= cap_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec && is_push && !refuse)
        begin
            mem[addr] <= cmd.push_value;
        end
        if (ctl.exec)
        begin
            rd_data_reg   <= mem[addr];
            pend_side_reg <= side;
        end
        if (ctl.load_direct)
        begin
            rsp_reg.side <= side;
            if (refuse)
            begin
                rsp_reg.status       <= is_push ? ST_FULL : ST_EMPTY;
                rsp_reg.result_value <= '0;
            end
            else
            begin
                rsp_reg.status       <= ST_PUSHED;
                rsp_reg.result_value <= cmd.push_value;
            end
        end
        else if (ctl.load_read)
        begin
            rsp_reg.status       <= ST_POPPED;
            rsp_reg.side         <= pend_side_reg;
            rsp_reg.result_value <= rd_data_reg;
        end
    end

    assign sts.is_push  = is_push;
    assign sts.refuse   = refuse;
    assign sts.rsp_busy = rsp_valid_reg;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/bounded_double_ended_queue.sv =====
// Bounded double-ended queue: a ring buffer with push and pop at both ends.
// Pushes, full and empty results appear in the cycle after the request is taken.
// Pops pass through the registered ring buffer memory read, then the response register.
// One push per cycle while responses are taken; requests wait while a pop reads.
// Asynchronous active-low reset empties the queue and sets capacity to 16;
// memory contents are not cleared. Depends on bdq_pkg, bdq_ctrl and bdq_dp.
module bounded_double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cap_we,
    input  logic [bdq_pkg::CAP_BITS-1:0]  cap_wdata,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  bdq_pkg::cmd_item_t            cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output bdq_pkg::rsp_item_t            rsp
);
    import bdq_pkg::*;

    ctl_t ctl;
    sts_t sts;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    bdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap_we    (cap_we),
        .cap_wdata (cap_wdata),
        .cmd       (cmd),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

// ===== rtl/bdq_checker.sv =====
// Port-level checker for the bounded double-ended queue and its bind.
// Depends on bdq_pkg and the top level bounded_double_ended_queue.
module bdq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input bdq_pkg::rsp_item_t rsp
);
    import bdq_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("Response changed while stalled.");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !cmd_ready)
        else $error("Request taken while the response register is held.");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> rsp_valid || !cmd_ready)
        else $error("Accepted request produced neither a response nor a busy cycle.");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_EMPTY)
        |-> rsp.result_value == '0)
        else $error("Refused request returned a nonzero value.");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
